[rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0]  ESC_BYTE = 8'hAA;
  localparam logic [7:0]  HDR_BYTE = 8'hCC;
  localparam logic [7:0]  END_BYTE = 8'hEE;
  localparam logic [7:0]  LIT_BYTE = 8'h00;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_HUNT_ESC = 2'd1,
    PH_BODY     = 2'd2,
    PH_BODY_ESC = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_COMMAND = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_CRC_BAD   = 2'd1,
    ST_BAD_ESC   = 2'd2,
    ST_TOO_SHORT = 2'd3
  } frame_status_t;

endpackage

[rtl/sfr_if.sv]
// ----------------------------------------------------------------------------
// sfr_byte_if / sfr_result_if
// Valid/ready channels for received bytes and deframed results.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] data_byte;
  logic [1:0] frame_status;
  logic       last;

  modport source (output valid, output item_kind, output data_byte,
                  output frame_status, output last, input ready);
  modport sink   (input valid, input item_kind, input data_byte,
                  input frame_status, input last, output ready);
endinterface

[rtl/sfr_crc_step.sv]
// ----------------------------------------------------------------------------
// sfr_crc_step
// One-byte CRC16-CCITT update, MSB first, polynomial 1021.
// ----------------------------------------------------------------------------
module sfr_crc_step (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import sfr_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_next = c;
  end

endmodule

[rtl/sfr_deframer.sv]
// ----------------------------------------------------------------------------
// sfr_deframer
// Frame state, unstuffing, two-byte CRC delay and the result register.
// ----------------------------------------------------------------------------
module sfr_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic [7:0]          byte_data,
  output logic                byte_take,
  sfr_result_if.source        result
);
  import sfr_pkg::*;

  phase_t        phase, phase_next;
  logic [7:0]    d0, d1, d0_next, d1_next;
  logic [1:0]    count, count_next;
  logic [15:0]   crc, crc_next, crc_upd;
  logic          cmd_sent, cmd_sent_next;

  logic          push;
  logic [7:0]    push_val;
  logic          emit;
  item_kind_t    kind;
  logic [7:0]    data;
  frame_status_t status;
  logic          last;

  logic          o_valid;
  logic [1:0]    o_kind;
  logic [7:0]    o_data;
  logic [1:0]    o_status;
  logic          o_last;

  sfr_crc_step u_crc (
    .crc      (crc),
    .data     (d0),
    .crc_next (crc_upd)
  );

  // Advance when the result register is free or being drained.
  assign byte_take = byte_valid && (!o_valid || result.ready);

  always_comb begin
    phase_next    = phase;
    d0_next       = d0;
    d1_next       = d1;
    count_next    = count;
    crc_next      = crc;
    cmd_sent_next = cmd_sent;
    push          = 1'b0;
    push_val      = byte_data;
    emit          = 1'b0;
    kind          = KIND_END;
    data          = 8'h00;
    status        = ST_GOOD;
    last          = 1'b0;

    case (phase)
      PH_HUNT: begin
        if (byte_data == ESC_BYTE) phase_next = PH_HUNT_ESC;
      end
      PH_HUNT_ESC: begin
        if (byte_data == HDR_BYTE) begin
          phase_next    = PH_BODY;
          count_next    = 2'd0;
          crc_next      = CRC_INIT;
          cmd_sent_next = 1'b0;
        end else if (byte_data != ESC_BYTE) begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (byte_data == ESC_BYTE) begin
          phase_next = PH_BODY_ESC;
        end else begin
          push = 1'b1;
        end
      end
      PH_BODY_ESC: begin
        if (byte_data == LIT_BYTE) begin
          phase_next = PH_BODY;
          push       = 1'b1;
          push_val   = ESC_BYTE;
        end else begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          kind       = KIND_END;
          last       = 1'b1;
          if (byte_data != END_BYTE) begin
            status = ST_BAD_ESC;
          end else if (!cmd_sent || count != 2'd2) begin
            status = ST_TOO_SHORT;
          end else if ({d1, d0} == crc) begin
            status = ST_GOOD;
          end else begin
            status = ST_CRC_BAD;
          end
        end
      end
      default: phase_next = PH_HUNT;
    endcase

    // Hold the last two bytes back; release the oldest once the delay is full.
    if (push) begin
      if (count != 2'd2) begin
        if (count[0]) d1_next = push_val;
        else          d0_next = push_val;
        count_next = count + 2'd1;
      end else begin
        d0_next       = d1;
        d1_next       = push_val;
        crc_next      = crc_upd;
        cmd_sent_next = 1'b1;
        emit          = 1'b1;
        kind          = cmd_sent ? KIND_PAYLOAD : KIND_COMMAND;
        data          = d0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      count    <= 2'd0;
      crc      <= CRC_INIT;
      cmd_sent <= 1'b0;
    end else if (byte_take) begin
      phase    <= phase_next;
      count    <= count_next;
      crc      <= crc_next;
      cmd_sent <= cmd_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      d0 <= d0_next;
      d1 <= d1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (byte_take) begin
      o_valid <= emit;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && emit) begin
      o_kind   <= kind;
      o_data   <= data;
      o_status <= status;
      o_last   <= last;
    end
  end

  assign result.valid        = o_valid;
  assign result.item_kind    = o_kind;
  assign result.data_byte    = o_data;
  assign result.frame_status = o_status;
  assign result.last         = o_last;

endmodule

[rtl/stuffed_frame_receiver_crc16_top.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_top
// Byte-stuffed frame receiver with CRC16-CCITT check.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per request. Bytes are dropped until the
//   header AA CC; inside a frame AA 00 stands for AA and AA EE closes it.
//   report carries the command byte, the payload bytes and one frame end
//   report per frame (last = 1) with good, CRC mismatch, bad escape or too
//   short. Drop a payload already taken when the report is not good.
//   The two trailing CRC bytes are held in a two-byte delay and never sent.
// Timing:
//   One byte per cycle sustained while report takes results. A byte is
//   registered at the input, then processed by the state/CRC logic into
//   the result register.
// Reset:
//   rst clears both registers' valid flags and returns to header hunting.
// Stall:
//   While report is stalled with a result pending, the input register holds
//   one byte and then rx.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc16_top (
  input  logic          clk,
  input  logic          rst,
  sfr_byte_if.sink      rx,
  sfr_result_if.source  report
);
  import sfr_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_take;

  assign rx.ready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  sfr_deframer u_deframer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (in_valid),
    .byte_data  (in_byte),
    .byte_take  (in_take),
    .result     (report)
  );

endmodule

[sim/tb_stuffed_frame_receiver_crc16_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver_crc16_top
// Self-checking bench for the byte-stuffed frame receiver with CRC16 check.
// Sends noise, well-formed frames and broken frames byte by byte with random
// gaps and output stalls. A deframer predictor in the bench tracks header
// hunting, unstuffing, the two-byte CRC hold-back and the running CRC. Every
// result the block gives is compared field by field with the oldest expected
// one.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver_crc16_top;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 8;

  typedef logic [7:0] bytes_t[$];

  typedef struct {
    item_kind_t    kind;
    logic [7:0]    data;
    frame_status_t status;
    logic          last;
  } frame_out_t;

  typedef enum logic [2:0] {
    TAIL_GOOD,
    TAIL_CRC_FLIP,
    TAIL_RAW,
    TAIL_ESC_HDR,
    TAIL_ESC_ESC,
    TAIL_ESC_ANY
  } tail_t;

  logic clk;
  logic rst;

  sfr_byte_if   rx_ch();
  sfr_result_if rep_ch();

  stuffed_frame_receiver_crc16_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .report (rep_ch)
  );

  // deframer predictor state
  phase_t      ph        = PH_HUNT;
  logic [7:0]  held[2]   = '{8'h00, 8'h00};
  int unsigned held_cnt  = 0;
  logic [15:0] fcs_run   = CRC_INIT;
  logic        cmd_sent  = 1'b0;

  frame_out_t  pending_q[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles     = 0;
  bit          idle_on    = 1'b1;
  int unsigned stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Push an unstuffed byte through the hold-back; emit the oldest when full.
  function automatic void shift_in(logic [7:0] b);
    frame_out_t r;
    if (held_cnt < 2) begin
      held[held_cnt[0]] = b;
      held_cnt++;
    end else begin
      r.kind   = cmd_sent ? KIND_PAYLOAD : KIND_COMMAND;
      r.data   = held[0];
      r.status = ST_GOOD;
      r.last   = 1'b0;
      pending_q.insert(pending_q.size(), r);
      fcs_run  = crc_next(fcs_run, held[0]);
      cmd_sent = 1'b1;
      held[0]  = held[1];
      held[1]  = b;
    end
  endfunction

  function automatic void deframe(logic [7:0] b);
    frame_out_t r;
    case (ph)
      PH_HUNT: begin
        if (b == ESC_BYTE) ph = PH_HUNT_ESC;
      end
      PH_HUNT_ESC: begin
        if (b == HDR_BYTE) begin
          ph       = PH_BODY;
          held_cnt = 0;
          fcs_run  = CRC_INIT;
          cmd_sent = 1'b0;
        end else if (b != ESC_BYTE) begin
          ph = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (b == ESC_BYTE) ph = PH_BODY_ESC;
        else shift_in(b);
      end
      default: begin
        if (b == LIT_BYTE) begin
          ph = PH_BODY;
          shift_in(ESC_BYTE);
        end else begin
          ph     = PH_HUNT;
          r.kind = KIND_END;
          r.data = 8'h00;
          r.last = 1'b1;
          if (b != END_BYTE) r.status = ST_BAD_ESC;
          else if (!cmd_sent || held_cnt < 2) r.status = ST_TOO_SHORT;
          else if ({held[1], held[0]} == fcs_run) r.status = ST_GOOD;
          else r.status = ST_CRC_BAD;
          pending_q.insert(pending_q.size(), r);
        end
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Leaves valid high after the handshake so back-to-back requests need no bubble.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    deframe(b);
    bytes_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    send_byte(b);
    if (b == ESC_BYTE) send_byte(LIT_BYTE);
  endtask

  task automatic send_frame(input bytes_t body, input tail_t tail, input bit dbl_esc);
    logic [15:0] fcs;
    logic [7:0]  b;
    fcs = CRC_INIT;
    send_byte(ESC_BYTE);
    if (dbl_esc) send_byte(ESC_BYTE);
    send_byte(HDR_BYTE);
    foreach (body[i]) begin
      send_stuffed(body[i]);
      fcs = crc_next(fcs, body[i]);
    end
    if (tail == TAIL_GOOD || tail == TAIL_CRC_FLIP) begin
      if (tail == TAIL_CRC_FLIP) fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
      send_stuffed(fcs[7:0]);
      send_stuffed(fcs[15:8]);
    end
    send_byte(ESC_BYTE);
    case (tail)
      TAIL_ESC_HDR: send_byte(HDR_BYTE);
      TAIL_ESC_ESC: begin
        // second AA is swallowed by the error, so the CC must not open a frame
        send_byte(ESC_BYTE);
        send_byte(HDR_BYTE);
      end
      TAIL_ESC_ANY: begin
        do b = 8'($urandom); while (b == LIT_BYTE || b == END_BYTE);
        send_byte(b);
      end
      default: send_byte(END_BYTE);
    endcase
  endtask

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return ESC_BYTE;
    if (r < 25) return LIT_BYTE;
    if (r < 30) return END_BYTE;
    if (r < 33) return HDR_BYTE;
    return 8'($urandom);
  endfunction

  function automatic bytes_t rand_body(int unsigned n);
    bytes_t q;
    repeat (n) q.insert(q.size(), rand_byte());
    return q;
  endfunction

  task automatic random_frame();
    int unsigned r;
    int unsigned n;
    tail_t       tail;
    r = $urandom_range(0, 99);
    n = (r < 90) ? $urandom_range(0, 12) : $urandom_range(13, 48);
    r = $urandom_range(0, 99);
    if (r < 60)      tail = TAIL_GOOD;
    else if (r < 72) tail = TAIL_CRC_FLIP;
    else if (r < 80) tail = TAIL_RAW;
    else if (r < 86) tail = TAIL_ESC_HDR;
    else if (r < 90) tail = TAIL_ESC_ESC;
    else             tail = TAIL_ESC_ANY;
    send_frame(rand_body(n), tail, $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(rand_byte());
    end
  endtask

  task automatic test_directed();
    bytes_t none;
    // noise and stray header bytes while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(ESC_BYTE);
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    // AA AA CC opens a frame; body holds the extremes and a stuffed AA
    send_frame('{8'hFF, ESC_BYTE, 8'h00}, TAIL_GOOD, 1'b1);
    send_frame(none, TAIL_RAW, 1'b0);
    send_frame('{8'h12, 8'h34}, TAIL_RAW, 1'b0);
    send_frame('{8'h5A}, TAIL_GOOD, 1'b0);
    send_frame('{8'h01, 8'h80}, TAIL_CRC_FLIP, 1'b0);
    send_frame('{8'h7E}, TAIL_ESC_HDR, 1'b0);
    send_frame('{8'hC3}, TAIL_ESC_ESC, 1'b0);
  endtask

  task automatic test_random_frames();
    idle_on = 1'b1;
    while (bytes_sent < 800) random_frame();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    while (bytes_sent < 1040) random_frame();
    idle_on = 1'b1;
  endtask

  // output side: random stalls, long ones now and then
  initial begin
    int unsigned r;
    rep_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        rep_ch.ready <= 1'b0;
        stall_left--;
      end else if (!idle_on) begin
        rep_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rep_ch.ready <= 1'b1;
        end else begin
          rep_ch.ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    frame_out_t e;
    if (!rst && rep_ch.valid && rep_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: kind %0d data %02h status %0d last %0b", $time,
                 rep_ch.item_kind, rep_ch.data_byte, rep_ch.frame_status, rep_ch.last);
        mismatches++;
      end else begin
        e = pending_q.pop_front();
        if (rep_ch.item_kind !== e.kind) begin
          $display("%0t item_kind: expected %0d, actual %0d", $time, e.kind, rep_ch.item_kind);
          mismatches++;
        end
        if (rep_ch.data_byte !== e.data) begin
          $display("%0t data_byte: expected %02h, actual %02h", $time, e.data,
                   rep_ch.data_byte);
          mismatches++;
        end
        if (rep_ch.frame_status !== e.status) begin
          $display("%0t frame_status: expected %0d, actual %0d", $time, e.status,
                   rep_ch.frame_status);
          mismatches++;
        end
        if (rep_ch.last !== e.last) begin
          $display("%0t last: expected %0b, actual %0b", $time, e.last, rep_ch.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_frames();
    test_back_to_back();

    rx_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
